// ===== sv/cbt_pkg.sv =====
// Package for the tone-range color balance block.
// Shared widths, register index codes and tone weight functions; no dependencies.
package cbt_pkg;

    localparam int PIX_W = 8;
    localparam int ADJ_W = 9;
    localparam int CFG_W = 3 * ADJ_W;
    localparam int SUM_W = 12;
    localparam int WORD_W = 3 * PIX_W;

    typedef enum logic [1:0] {
        CFG_RED   = 2'd0,
        CFG_GREEN = 2'd1,
        CFG_BLUE  = 2'd2
    } cfg_index_t;

    // shadow ramp weight, rounded to nearest; evaluated at elaboration
    function automatic longint cbt_shadow_w(input int v, input int frac);
        longint r;
        r = 117 - v;
        if (r < 0) r = 0;
        if (r > 64) r = 64;
        return (((r * 357) <<< frac) + 64'sd6400) / 64'sd12800;
    endfunction

    // midtone weight: product of the rising and falling ramps
    function automatic longint cbt_midtone_w(input int v, input int frac);
        longint a;
        longint b;
        a = v - 53;
        if (a < 0) a = 0;
        if (a > 64) a = 64;
        b = 202 - v;
        if (b < 0) b = 0;
        if (b > 64) b = 64;
        return (((a * b * 357) <<< frac) + 64'sd409600) / 64'sd819200;
    endfunction

endpackage

// ===== sv/cbt_weight.sv =====
// Tone weight lookup for one channel value: shadow, midtone and highlight.
// Depends on cbt_pkg for the weight functions that fill the constant tables.
module cbt_weight import cbt_pkg::*; #(
    parameter int FRAC = 10
) (
    input  logic [PIX_W-1:0] v,
    output logic [FRAC:0]    w_sh,
    output logic [FRAC:0]    w_mid,
    output logic [FRAC:0]    w_hi
);

    localparam int WW = FRAC + 1;
    localparam int DEPTH = 1 << PIX_W;

    logic [WW-1:0] sh_tab  [DEPTH];
    logic [WW-1:0] mid_tab [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_tab
        assign sh_tab[i]  = WW'(cbt_shadow_w(i, FRAC));
        assign mid_tab[i] = WW'(cbt_midtone_w(i, FRAC));
    end

    // highlight weight is the shadow weight mirrored at 255 - v
    assign w_sh  = sh_tab[v];
    assign w_mid = mid_tab[v];
    assign w_hi  = sh_tab[~v];

endmodule

// ===== sv/cbt_channel.sv =====
// Balance datapath for one color channel: three weighted adds and a clamp.
// Depends on cbt_pkg and cbt_weight.
module cbt_channel import cbt_pkg::*; #(
    parameter int FRAC = 10
) (
    input  logic [PIX_W-1:0] v,
    input  logic [CFG_W-1:0] adj,
    output logic [PIX_W-1:0] y
);

    localparam int PW = ADJ_W + FRAC + 2;
    localparam int AW = SUM_W + FRAC + 1;

    logic [FRAC:0]           w_sh;
    logic [FRAC:0]           w_mid;
    logic [FRAC:0]           w_hi;
    logic signed [PW-1:0]    p_sh;
    logic signed [PW-1:0]    p_mid;
    logic signed [PW-1:0]    p_hi;
    logic signed [SUM_W-1:0] n0;
    logic signed [SUM_W-1:0] n1;
    logic signed [SUM_W-1:0] n2;
    logic signed [SUM_W-1:0] n3;

    cbt_weight #(.FRAC(FRAC)) u_weight (
        .v     (v),
        .w_sh  (w_sh),
        .w_mid (w_mid),
        .w_hi  (w_hi)
    );

    // add a scaled product, then truncate toward zero
    function automatic logic signed [SUM_W-1:0] add_trunc(
        input logic signed [SUM_W-1:0] n,
        input logic signed [PW-1:0]    p
    );
        logic signed [AW-1:0] acc;
        logic signed [AW-1:0] q;
        acc = (AW'(n) <<< FRAC) + AW'(p);
        q = acc >>> FRAC;
        if (acc[AW-1] && (acc[FRAC-1:0] != '0)) begin
            q = q + AW'(1);
        end
        return q[SUM_W-1:0];
    endfunction

    assign p_sh  = PW'($signed(adj[ADJ_W-1:0]) * $signed({1'b0, w_sh}));
    assign p_mid = PW'($signed(adj[2*ADJ_W-1:ADJ_W]) * $signed({1'b0, w_mid}));
    assign p_hi  = PW'($signed(adj[3*ADJ_W-1:2*ADJ_W]) * $signed({1'b0, w_hi}));

    assign n0 = $signed({{(SUM_W - PIX_W){1'b0}}, v});
    assign n1 = add_trunc(n0, p_sh);
    assign n2 = add_trunc(n1, p_mid);
    assign n3 = add_trunc(n2, p_hi);

    always_comb begin
        if (n3 < 0) begin
            y = '0;
        end else if (n3 > $signed(SUM_W'(255))) begin
            y = '1;
        end else begin
            y = n3[PIX_W-1:0];
        end
    end

endmodule

// ===== sv/color_balance_tone_ranges.sv =====
// Color balance over shadows, midtones and highlights for 8-bit RGB pixels.
// Takes one pixel word per clock and returns one balanced pixel word per clock
// while the result side accepts: an input register, then the weight tables,
// three weighted adds and the clamp per channel ahead of the result register.
// Both registers hold while the result side stalls. The user must write the
// adjustments through the cfg port only while no pixels are in flight; the
// block does not enforce this. Depends on cbt_pkg and cbt_channel.
module color_balance_tone_ranges import cbt_pkg::*; #(
    parameter int WEIGHT_FRAC_BITS = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [WORD_W-1:0] s_tdata,    // blue_in, green_in, red_in
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [WORD_W-1:0] m_tdata     // blue_out, green_out, red_out
);

    logic [CFG_W-1:0]  red_adj_reg;
    logic [CFG_W-1:0]  green_adj_reg;
    logic [CFG_W-1:0]  blue_adj_reg;
    logic              in_valid_reg;
    logic [WORD_W-1:0] in_data_reg;
    logic              out_valid_reg;
    logic [WORD_W-1:0] out_data_reg;
    logic [WORD_W-1:0] out_data_next;
    logic              out_load;
    logic              in_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_adj_reg   <= '0;
            green_adj_reg <= '0;
            blue_adj_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_RED:   red_adj_reg   <= cfg_data;
                CFG_GREEN: green_adj_reg <= cfg_data;
                CFG_BLUE:  blue_adj_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign out_load = !out_valid_reg || m_tready;
    assign in_load  = !in_valid_reg || out_load;
    assign s_tready = in_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_load) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_load) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load && s_tvalid) begin
            in_data_reg <= s_tdata;
        end
        if (out_load && in_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

    cbt_channel #(.FRAC(WEIGHT_FRAC_BITS)) u_blue (
        .v   (in_data_reg[PIX_W-1:0]),
        .adj (blue_adj_reg),
        .y   (out_data_next[PIX_W-1:0])
    );

    cbt_channel #(.FRAC(WEIGHT_FRAC_BITS)) u_green (
        .v   (in_data_reg[2*PIX_W-1:PIX_W]),
        .adj (green_adj_reg),
        .y   (out_data_next[2*PIX_W-1:PIX_W])
    );

    cbt_channel #(.FRAC(WEIGHT_FRAC_BITS)) u_red (
        .v   (in_data_reg[3*PIX_W-1:2*PIX_W]),
        .adj (red_adj_reg),
        .y   (out_data_next[3*PIX_W-1:2*PIX_W])
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== sv/cbt_checker.sv =====
// Port-level checks for color_balance_tone_ranges, attached by bind.
// Depends on cbt_pkg for the word width.
module cbt_checker import cbt_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [WORD_W-1:0] m_tdata
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

    a_word_has_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result word without an input word two cycles before");

    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_data_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result word changed while stalled");

endmodule

bind color_balance_tone_ranges cbt_checker u_cbt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/color_balance_tone_ranges_tb.sv =====
// Testbench for color_balance_tone_ranges: random pixel words under changing adjustments,
// checked word by word against a predictor of the tone weights and weighted adds.
// Depends on cbt_pkg and the block's RTL only.
`timescale 1ns / 1ps

module color_balance_tone_ranges_tb;
    import cbt_pkg::*;

    localparam int WEIGHT_FRAC = 10;
    localparam int RANDOM_PHASES = 8;
    localparam int WORDS_PER_PHASE = 212;
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam logic [PIX_W-1:0] TONE_MARKS [12] = '{
        8'd0, 8'd1, 8'd53, 8'd54, 8'd85, 8'd117, 8'd118, 8'd137, 8'd138, 8'd201, 8'd202, 8'd255
    };

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pixel_t;

    class tone_balance_predictor;
        logic [CFG_W-1:0] red_adj;
        logic [CFG_W-1:0] green_adj;
        logic [CFG_W-1:0] blue_adj;
        pixel_t expected_pixels[$];
        int mismatches;
        int checked;

        function new();
            red_adj = '0;
            green_adj = '0;
            blue_adj = '0;
            mismatches = 0;
            checked = 0;
        endfunction

        function void set_adjust(logic [1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_RED:   red_adj = val;
                CFG_GREEN: green_adj = val;
                CFG_BLUE:  blue_adj = val;
                default: ;
            endcase
        endfunction

        function int ramp_weight(int v);
            longint r;
            r = 117 - v;
            if (r < 0) r = 0;
            if (r > 64) r = 64;
            return int'((((r * 357) << WEIGHT_FRAC) + 6400) / 12800);
        endfunction

        function int hump_weight(int v);
            longint up;
            longint down;
            up = v - 53;
            down = 202 - v;
            if (up < 0) up = 0;
            if (up > 64) up = 64;
            if (down < 0) down = 0;
            if (down > 64) down = 64;
            return int'((((up * down * 357) << WEIGHT_FRAC) + 409600) / 819200);
        endfunction

        function logic [PIX_W-1:0] balanced_channel(logic [PIX_W-1:0] v, logic [CFG_W-1:0] adj);
            int one;
            int vi;
            int n;
            int s_adj;
            int m_adj;
            int h_adj;
            one = 1 << WEIGHT_FRAC;
            vi = v;
            s_adj = $signed(adj[8:0]);
            m_adj = $signed(adj[17:9]);
            h_adj = $signed(adj[26:18]);
            n = vi;
            n = (n * one + s_adj * ramp_weight(vi)) / one;
            n = (n * one + m_adj * hump_weight(vi)) / one;
            n = (n * one + h_adj * ramp_weight(255 - vi)) / one;
            if (n < 0) n = 0;
            if (n > 255) n = 255;
            return n[PIX_W-1:0];
        endfunction

        function void note_pixel(pixel_t p);
            pixel_t want;
            want.red = balanced_channel(p.red, red_adj);
            want.green = balanced_channel(p.green, green_adj);
            want.blue = balanced_channel(p.blue, blue_adj);
            expected_pixels = {expected_pixels, want};
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10) $display("%s", msg);
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            if (expected_pixels.size() == 0) begin
                report($sformatf("unexpected word %h", got));
                return;
            end
            want = expected_pixels.pop_front();
            checked++;
            if (got.blue !== want.blue)
                report($sformatf("word %0d blue: expected %0d, got %0d",
                                 checked, want.blue, got.blue));
            if (got.green !== want.green)
                report($sformatf("word %0d green: expected %0d, got %0d",
                                 checked, want.green, got.green));
            if (got.red !== want.red)
                report($sformatf("word %0d red: expected %0d, got %0d",
                                 checked, want.red, got.red));
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_RED;
    logic [CFG_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [WORD_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [WORD_W-1:0] m_tdata;

    tone_balance_predictor balance_pred = new();
    bit quiet_phase = 1'b0;
    int sent = 0;
    int settings = 0;

    always #5 aclk = ~aclk;

    color_balance_tone_ranges i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    function automatic int pick_gap();
        int r;
        if (quiet_phase) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [ADJ_W-1:0] pick_adjust();
        case ($urandom_range(0, 9))
            0: return 9'h0FF;
            1: return 9'h100;
            2: return 9'h000;
            3: return 9'h1FF;
            4: return 9'h001;
            default: return ADJ_W'($urandom);
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] pick_level();
        if ($urandom_range(0, 9) < 2) return TONE_MARKS[$urandom_range(0, 11)];
        return PIX_W'($urandom_range(0, 255));
    endfunction

    task automatic send_pixel(pixel_t p);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= p;
        do @(posedge aclk); while (!s_tready);
        balance_pred.note_pixel(p);
        sent++;
    endtask

    // drop valid and hold until every expected word has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (balance_pred.expected_pixels.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_adjust(logic [1:0] idx, logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        balance_pred.set_adjust(idx, val);
    endtask

    task automatic configure(logic [CFG_W-1:0] r, logic [CFG_W-1:0] g, logic [CFG_W-1:0] b);
        drain();
        write_adjust(CFG_RED, r);
        write_adjust(CFG_GREEN, g);
        write_adjust(CFG_BLUE, b);
        write_adjust(CFG_UNUSED, CFG_W'($urandom));
        cfg_we <= 1'b0;
        settings++;
    endtask

    initial begin
        int hold;
        int r;
        bit ready_now;
        hold = 0;
        ready_now = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) balance_pred.check_pixel(m_tdata);
            if (hold == 0) begin
                r = $urandom_range(0, 99);
                if (quiet_phase || r < 70) begin
                    ready_now = 1'b1;
                    hold = $urandom_range(1, 8);
                end else if (r < 95) begin
                    ready_now = 1'b0;
                    hold = $urandom_range(1, 3);
                end else begin
                    ready_now = 1'b0;
                    hold = $urandom_range(8, 40);
                end
            end
            hold--;
            m_tready <= ready_now;
        end
    end

    initial begin
        pixel_t p;
        logic [CFG_W-1:0] packs [3];
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset adjustments pass pixels through
        send_pixel('0);
        send_pixel('1);

        configure({3{9'h0FF}}, {3{9'h0FF}}, {3{9'h0FF}});
        for (int i = 0; i < 12; i++) begin
            p = {TONE_MARKS[i], TONE_MARKS[(i + 4) % 12], TONE_MARKS[(i + 8) % 12]};
            send_pixel(p);
        end
        configure({3{9'h100}}, {3{9'h100}}, {3{9'h100}});
        for (int i = 0; i < 12; i++) begin
            p = {TONE_MARKS[(i + 8) % 12], TONE_MARKS[i], TONE_MARKS[(i + 4) % 12]};
            send_pixel(p);
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            foreach (packs[c]) packs[c] = {pick_adjust(), pick_adjust(), pick_adjust()};
            configure(packs[0], packs[1], packs[2]);
            quiet_phase = (ph == 2 || ph == 5);
            for (int k = 0; k < WORDS_PER_PHASE; k++) begin
                if (ph == 3 && k == WORDS_PER_PHASE / 2) drain();
                p = {pick_level(), pick_level(), pick_level()};
                send_pixel(p);
            end
            quiet_phase = 1'b0;
        end

        s_tvalid <= 1'b0;
        while (balance_pred.expected_pixels.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Sent %0d pixel words across %0d adjustment settings; %0d results checked.",
                 sent, settings, balance_pred.checked);
        $display("Mismatches: %0d", balance_pred.mismatches);
        if (balance_pred.mismatches == 0 && balance_pred.expected_pixels.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d words outstanding", balance_pred.expected_pixels.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
